@@ design/contiguous_upper_memory_extent_core_assert.svh @@
// Assertion macros for the contiguous upper memory extent core.
`ifndef CONTIGUOUS_UPPER_MEMORY_EXTENT_CORE_ASSERT_SVH
`define CONTIGUOUS_UPPER_MEMORY_EXTENT_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, clocked on aclk, off during reset.
`define CUME_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cume: same-cycle check failed");
// Next-cycle implication, clocked on aclk, off during reset.
`define CUME_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cume: next-cycle check failed");
`else
`define CUME_ASSERT_IMPL(name, ante, cons)
`define CUME_ASSERT_NEXT(name, ante, cons)
`endif

`endif

@@ design/cume_pkg.sv @@
// Shared types and constants for the contiguous upper memory extent core.
package cume_pkg;

    // Region table geometry
    localparam int MAX_ENTRIES = 128;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Field widths
    localparam int ADDR_W      = 64;
    localparam int TYPE_W      = 32;
    localparam int FRONT_W     = 33;
    localparam int LIMIT_W     = 32;
    localparam int UPPER_KB_W  = 22;
    localparam int S_DATA_W    = 128;
    localparam int M_DATA_W    = 56;

    // Address constants
    localparam logic [FRONT_W-1:0] FRONTIER_START = 33'h0_0010_0000;
    localparam logic [FRONT_W-1:0] FOUR_GIB       = 33'h1_0000_0000;
    localparam logic [LIMIT_W-1:0] RESERVED_START = 32'hFFF0_0000;
    localparam logic [ADDR_W-1:0]  ADDR_MAX       = '1;
    localparam logic [TYPE_W-1:0]  TYPE_RAM       = 32'd1;

    // One stored region
    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
        logic              is_ram;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Outcome of checking one entry against the scan state
    typedef struct packed {
        logic               move;
        logic [FRONT_W-1:0] frontier;
        logic [LIMIT_W-1:0] limit;
    } eval_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

@@ design/cume_ram.sv @@
// Generic simple dual-port RAM with registered read.
module cume_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/cume_eval.sv @@
// Checks one region entry against the current frontier and reserved limit.
module cume_eval (
    input  cume_pkg::entry_t               entry,
    input  logic [cume_pkg::FRONT_W-1:0]   frontier,
    input  logic [cume_pkg::LIMIT_W-1:0]   limit,
    output cume_pkg::eval_t                res
);
    import cume_pkg::*;

    logic [FRONT_W-1:0] lo_raw;
    logic [FRONT_W-1:0] lo;
    logic [FRONT_W-1:0] next_front;
    logic               high;
    logic               live;

    // Clip start to the frontier, drop regions at or above 4 GiB
    always_comb begin
        lo_raw     = {1'b0, entry.start_addr[31:0]};
        high       = |entry.start_addr[63:32];
        lo         = (lo_raw < frontier) ? frontier : lo_raw;
        live       = !high && (entry.end_addr > {31'b0, lo});
        next_front = (entry.end_addr > {31'b0, FOUR_GIB}) ? FOUR_GIB
                                                          : entry.end_addr[FRONT_W-1:0];
    end

    // Extend through RAM at the frontier; a reserved region below the limit lowers it
    always_comb begin
        res.move     = 1'b0;
        res.frontier = frontier;
        res.limit    = limit;
        if (live) begin
            if (entry.is_ram && (lo == frontier)) begin
                if (next_front > frontier) begin
                    res.move     = 1'b1;
                    res.frontier = next_front;
                end
            end else if (!entry.is_ram && (lo < {1'b0, limit})) begin
                res.limit = lo[LIMIT_W-1:0];
            end
        end
    end

endmodule

@@ design/contiguous_upper_memory_extent_core.sv @@
// Top level of the contiguous upper memory extent core.
//
// Usage: a memory map arrives on the s_ channel, one region per request
// (s_tdata = base, length; s_tuser = type; s_tlast = final region). Regions
// go into a 128-entry table RAM at one per cycle while s_tready is high. Once
// a table is full, further regions are dropped and the result's overflow flag
// is set. The request with s_tlast high starts a scan of the table: a frontier
// begins at 1 MiB and is pushed through RAM regions that start at or below
// it, restarting from entry 0 after every push; reserved regions lower the
// reserved limit. The scan reads one entry per cycle through the single
// read port of the table RAM and ends once a full pass over the stored entries
// finds no push. From ST_DONE the result moves into the m_ output register
// once that register is free.
// s_tready is low from the final region until the result is registered.
// A stalled receiver only holds the result register; the next map may load
// meanwhile, and a later scan waits before its result is registered.
// Reset clears the entry count, the drop flag, the state and m_tvalid; the
// table contents need no clearing since only entries below the count are read.
module contiguous_upper_memory_extent_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Region requests
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cume_pkg::S_DATA_W-1:0]     s_tdata,  // [63:0] region_base, [127:64] region_length
    input  logic [cume_pkg::TYPE_W-1:0]       s_tuser,  // [31:0] region_type
    input  logic                              s_tlast,
    // Results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cume_pkg::M_DATA_W-1:0]     m_tdata,  // [21:0] upper_kb, [53:22] reserved_limit
    output logic                              m_tuser   // [0] overflow
);
    import cume_pkg::*;

    `include "contiguous_upper_memory_extent_core_assert.svh"

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 dropped_reg, dropped_next;
    logic                 ovf_reg, ovf_next;
    logic [CNT_W-1:0]     scan_len_reg, scan_len_next;
    logic [CNT_W-1:0]     rd_addr_reg, rd_addr_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [FRONT_W-1:0]   frontier_reg, frontier_next;
    logic [LIMIT_W-1:0]   limit_reg, limit_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    logic                 s_accept;
    logic                 has_room;
    logic                 ram_we;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    entry_t               wr_entry;
    entry_t               rd_entry;
    logic [ADDR_W:0]      end_sum;
    eval_t                ev;
    logic                 eval_on;
    logic                 extend;
    logic                 scan_done;
    logic                 out_free;
    logic [FRONT_W-1:0]   clipped;
    logic [FRONT_W-1:0]   extent;

    assign s_accept = s_tvalid && s_tready;
    assign has_room = (count_reg < CNT_W'(MAX_ENTRIES));
    assign ram_we   = s_accept && has_room;

    // Region entry built from the request; a wrapping end saturates
    always_comb begin
        end_sum             = {1'b0, s_tdata[63:0]} + {1'b0, s_tdata[127:64]};
        wr_entry.start_addr = s_tdata[63:0];
        wr_entry.end_addr   = end_sum[ADDR_W] ? ADDR_MAX : end_sum[ADDR_W-1:0];
        wr_entry.is_ram     = (s_tuser == TYPE_RAM);
    end

    cume_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);

    cume_eval u_eval (
        .entry    (rd_entry),
        .frontier (frontier_reg),
        .limit    (limit_reg),
        .res      (ev)
    );

    // Scan status
    assign eval_on   = (state_reg == ST_SCAN) && rd_pend_reg;
    assign extend    = eval_on && ev.move;
    assign scan_done = (state_reg == ST_SCAN) && (rd_addr_reg == scan_len_reg) && !extend;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_accept && s_tlast) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // State outputs: request ready and table read port
    always_comb begin
        s_tready  = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = rd_addr_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_LOAD: s_tready = 1'b1;
            ST_SCAN: begin
                if (extend) begin
                    ram_re    = 1'b1;
                    ram_raddr = '0;
                end else if (rd_addr_reg < scan_len_reg) begin
                    ram_re    = 1'b1;
                end
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    // Load bookkeeping and scan datapath
    always_comb begin
        count_next    = count_reg;
        dropped_next  = dropped_reg;
        ovf_next      = ovf_reg;
        scan_len_next = scan_len_reg;
        rd_addr_next  = rd_addr_reg;
        rd_pend_next  = rd_pend_reg;
        frontier_next = frontier_reg;
        limit_next    = limit_reg;

        if (s_accept) begin
            if (s_tlast) begin
                scan_len_next = has_room ? count_reg + CNT_W'(1) : count_reg;
                ovf_next      = dropped_reg || !has_room;
                count_next    = '0;
                dropped_next  = 1'b0;
                rd_addr_next  = '0;
                rd_pend_next  = 1'b0;
                frontier_next = FRONTIER_START;
                limit_next    = RESERVED_START;
            end else begin
                count_next    = has_room ? count_reg + CNT_W'(1) : count_reg;
                dropped_next  = dropped_reg || !has_room;
            end
        end

        if (state_reg == ST_SCAN) begin
            if (eval_on) begin
                frontier_next = ev.frontier;
                limit_next    = ev.limit;
            end
            if (extend) begin
                // restart from entry 0; read of entry 0 issued now
                rd_addr_next = CNT_W'(1);
                rd_pend_next = 1'b1;
            end else if (rd_addr_reg < scan_len_reg) begin
                rd_addr_next = rd_addr_reg + CNT_W'(1);
                rd_pend_next = 1'b1;
            end else begin
                rd_pend_next = 1'b0;
            end
        end
    end

    // Result formatting: cap frontier by the limit, extent in KiB above 1 MiB
    always_comb begin
        clipped = (frontier_reg > {1'b0, limit_reg}) ? {1'b0, limit_reg} : frontier_reg;
        extent  = clipped - FRONTIER_START;
    end

    // Output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if ((state_reg == ST_DONE) && out_free) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {2'b00, limit_reg, extent[UPPER_KB_W+9:10]};
            m_tuser_next  = ovf_reg;
        end else if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            dropped_reg  <= dropped_next;
            rd_pend_reg  <= rd_pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        ovf_reg      <= ovf_next;
        scan_len_reg <= scan_len_next;
        rd_addr_reg  <= rd_addr_next;
        frontier_reg <= frontier_next;
        limit_reg    <= limit_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks
    `CUME_ASSERT_NEXT(a_last_starts_scan, s_accept && s_tlast, (state_reg == ST_SCAN) && (count_reg == '0))
    `CUME_ASSERT_NEXT(a_limit_falls, state_reg == ST_SCAN, limit_reg <= $past(limit_reg))
    `CUME_ASSERT_NEXT(a_frontier_rises, state_reg == ST_SCAN, (frontier_reg >= $past(frontier_reg)) && (frontier_reg <= FOUR_GIB))
    `CUME_ASSERT_IMPL(a_read_in_range, state_reg == ST_SCAN, rd_addr_reg <= scan_len_reg)

endmodule
